// File: rtl/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types, character codes and byte classifiers for the chunked
// transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_I    = 8'h69;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_F    = 8'h66;

    // extension match progress: 0..3 chars matched, then full or failed
    localparam logic [2:0] EXT_NONE = 3'd0;
    localparam logic [2:0] EXT_FULL = 3'd4;
    localparam logic [2:0] EXT_FAIL = 3'd5;

    localparam logic [1:0] SEMI_NONE = 2'd0;
    localparam logic [1:0] SEMI_ONE  = 2'd1;
    localparam logic [1:0] SEMI_MANY = 2'd2;

    typedef enum logic [1:0] {
        HX_IDLE   = 2'd0,
        HX_DIGITS = 2'd1,
        HX_DONE   = 2'd2
    } hex_status_t;

    typedef struct packed {
        logic        prev_was_cr;
        hex_status_t hex_status;
        logic [1:0]  semi_cnt;
        logic [2:0]  ext_match;
        logic        ext_tail_ok;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        prev_was_cr: 1'b0,
        hex_status:  HX_IDLE,
        semi_cnt:    SEMI_NONE,
        ext_match:   EXT_NONE,
        ext_tail_ok: 1'b1
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c <= 8'h39)
            t = c - 8'h30;
        else if (c >= 8'h61)
            t = c - 8'h57;
        else
            t = c - 8'h37;
        return t[3:0];
    endfunction

    function automatic logic [7:0] ieof_char(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = CH_I;
            2'd1:    r = CH_E;
            2'd2:    r = CH_O;
            default: r = CH_F;
        endcase
        return r;
    endfunction

    // Control part of one line-text byte (size digits are handled by caller).
    function automatic line_state_t take_text_ctl(input line_state_t s,
                                                  input logic [7:0] c);
        line_state_t r;
        r = s;
        if (c == CH_SEMI) begin
            if (s.semi_cnt != SEMI_MANY)
                r.semi_cnt = s.semi_cnt + 2'd1;
        end
        else if (s.semi_cnt == SEMI_NONE) begin
            if ((s.hex_status != HX_DONE) && !((s.hex_status == HX_IDLE) && is_ws(c)))
                r.hex_status = is_hex(c) ? HX_DIGITS : HX_DONE;
        end
        else if (s.semi_cnt == SEMI_ONE) begin
            if (s.ext_match == EXT_FAIL) begin
                r.ext_match = EXT_FAIL;
            end
            else if (s.ext_match == EXT_FULL) begin
                if (!is_ws(c))
                    r.ext_tail_ok = 1'b0;
            end
            else if (!((s.ext_match == EXT_NONE) && is_ws(c))) begin
                if (c == ieof_char(s.ext_match[1:0]))
                    r.ext_match = s.ext_match + 3'd1;
                else
                    r.ext_match = EXT_FAIL;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/ctd_line_parse.sv
// ----------------------------------------------------------------------------
// ctd_line_parse
// Size line parser: one byte of chunk size line text per cycle, with the
// pending CR folded back in when no LF follows it.
// ----------------------------------------------------------------------------
module ctd_line_parse #(
    parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
    input  ctd_pkg::line_state_t   line_state,
    input  logic [SIZE_BITS-1:0]   size_accum,
    input  logic [7:0]             in_byte,
    output ctd_pkg::line_state_t   line_next,
    output logic [SIZE_BITS-1:0]   accum_next,
    output logic                   ovf_set,
    output logic                   line_end
);
    import ctd_pkg::*;

    line_state_t s_cr;
    line_state_t s_byte;
    logic        take_digit;

    assign line_end = line_state.prev_was_cr && (in_byte == CH_LF);

    // a CR never adds a digit, so at most one digit lands per cycle
    always_comb
    begin
        s_cr   = line_state.prev_was_cr ? take_text_ctl(line_state, CH_CR) : line_state;
        s_byte = take_text_ctl(s_cr, in_byte);

        take_digit = (in_byte != CH_SEMI) && (in_byte != CH_CR) &&
                     (s_cr.semi_cnt == SEMI_NONE) && (s_cr.hex_status != HX_DONE) &&
                     !((s_cr.hex_status == HX_IDLE) && is_ws(in_byte)) &&
                     is_hex(in_byte);

        if (in_byte == CH_CR) begin
            line_next             = s_cr;
            line_next.prev_was_cr = 1'b1;
        end
        else begin
            line_next             = s_byte;
            line_next.prev_was_cr = 1'b0;
        end

        ovf_set    = 1'b0;
        accum_next = size_accum;
        if (take_digit) begin
            if (size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                accum_next = '1;
                ovf_set    = 1'b1;
            end
            else begin
                accum_next = {size_accum[SIZE_BITS-5:0], hex_val(in_byte)};
            end
        end
    end

endmodule

// File: rtl/chunked_transfer_decoder.sv
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Chunk-encoded byte stream in, payload bytes and one end marker per payload
// out.
// ----------------------------------------------------------------------------
// Throughput: one byte accepted per clock, sustained, while results drain.
// A result appears in the cycle after the byte that causes it.
// The rate is set by the single-pass byte state update into the state and
// result registers; src_stall rises only while a held result is stalled.
// Reset (rst_n low, asynchronous): decoder returns to reading a size line,
// flags clear, result register empties.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder #(
    parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // request channel: encoded bytes
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    // result channel: payload bytes and end marker
    output logic       res_valid,
    input  logic       res_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic       ieof_seen,
    output logic       size_overflow
);
    import ctd_pkg::*;

    // Phase of the chunk framing. Codes above END_B are never entered and
    // behave as LINE (default arm below).
    typedef enum logic [2:0] {
        PH_LINE  = 3'd0,  // collecting a size line
        PH_DATA  = 3'd1,  // passing chunk data through
        PH_TRL_A = 3'd2,  // first dropped byte after data
        PH_TRL_B = 3'd3,  // second dropped byte after data
        PH_END_A = 3'd4,  // first dropped byte after zero-size line
        PH_END_B = 3'd5   // second one: emits the end marker
    } phase_t;

    phase_t               phase_reg;
    line_state_t          line_reg;
    logic [SIZE_BITS-1:0] size_accum_reg;
    logic [SIZE_BITS-1:0] bytes_left_reg;
    logic                 overflow_reg;

    logic                 res_valid_reg;
    logic                 kind_reg;
    logic [7:0]           data_byte_reg;
    logic                 ieof_reg;
    logic                 ovf_out_reg;

    logic                 accept;
    line_state_t          lp_next;
    logic [SIZE_BITS-1:0] lp_accum;
    logic                 lp_ovf;
    logic                 lp_end;
    logic [SIZE_BITS-1:0] left_dec;
    logic                 ext_ok;

    // A new request is held off only if the result register is full and
    // its consumer is stalling; otherwise the result slot frees this edge.
    assign src_stall = res_valid_reg && res_stall;
    assign accept    = src_valid && !src_stall;

    ctd_line_parse #(
        .SIZE_BITS (SIZE_BITS)
    ) u_line_parse (
        .line_state (line_reg),
        .size_accum (size_accum_reg),
        .in_byte    (in_byte),
        .line_next  (lp_next),
        .accum_next (lp_accum),
        .ovf_set    (lp_ovf),
        .line_end   (lp_end)
    );

    assign left_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    // final chunk's extension must be exactly one ';' then trimmed "ieof"
    assign ext_ok = (line_reg.semi_cnt == SEMI_ONE) && (line_reg.ext_match == EXT_FULL) &&
                    line_reg.ext_tail_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_LINE;
            line_reg       <= LINE_CLEAR;
            size_accum_reg <= '0;
            bytes_left_reg <= '0;
            overflow_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            kind_reg       <= 1'b0;
            data_byte_reg  <= 8'd0;
            ieof_reg       <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else begin
            if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;

            if (accept) begin
                case (phase_reg)
                    PH_DATA:
                    begin
                        res_valid_reg  <= 1'b1;
                        kind_reg       <= 1'b0;
                        data_byte_reg  <= in_byte;
                        ieof_reg       <= 1'b0;
                        ovf_out_reg    <= overflow_reg;
                        bytes_left_reg <= left_dec;
                        if (left_dec == '0)
                            phase_reg <= PH_TRL_A;
                    end
                    PH_TRL_A:
                    begin
                        phase_reg <= PH_TRL_B;
                    end
                    PH_TRL_B:
                    begin
                        line_reg       <= LINE_CLEAR;
                        size_accum_reg <= '0;
                        phase_reg      <= PH_LINE;
                    end
                    PH_END_A:
                    begin
                        phase_reg <= PH_END_B;
                    end
                    PH_END_B:
                    begin
                        res_valid_reg  <= 1'b1;
                        kind_reg       <= 1'b1;
                        data_byte_reg  <= 8'd0;
                        ieof_reg       <= ext_ok;
                        ovf_out_reg    <= overflow_reg;
                        overflow_reg   <= 1'b0;
                        bytes_left_reg <= '0;
                        line_reg       <= LINE_CLEAR;
                        size_accum_reg <= '0;
                        phase_reg      <= PH_LINE;
                    end
                    default:
                    begin
                        // size line byte; CR LF closes the line
                        if (lp_end) begin
                            line_reg.prev_was_cr <= 1'b0;
                            if (size_accum_reg != '0) begin
                                bytes_left_reg <= size_accum_reg;
                                phase_reg      <= PH_DATA;
                            end
                            else begin
                                phase_reg <= PH_END_A;
                            end
                        end
                        else begin
                            line_reg       <= lp_next;
                            size_accum_reg <= lp_accum;
                            phase_reg      <= PH_LINE;
                            if (lp_ovf)
                                overflow_reg <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign res_valid     = res_valid_reg;
    assign kind          = kind_reg;
    assign data_byte     = data_byte_reg;
    assign ieof_seen     = ieof_reg;
    assign size_overflow = ovf_out_reg;

    // data phase is only entered with a nonzero count and left at zero
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != '0))
        else $error("data phase with zero bytes left");

    a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_DATA)) |=>
            (res_valid && !kind && (data_byte == $past(in_byte))))
        else $error("data byte not forwarded");

    a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_END_B)) |=> (res_valid && kind && (data_byte == 8'd0) &&
                                                 (phase_reg == PH_LINE) && !overflow_reg))
        else $error("end marker or payload restart wrong");

    a_trailer_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((phase_reg == PH_TRL_A) || (phase_reg == PH_END_A))) |=>
            ((phase_reg == PH_TRL_B) || (phase_reg == PH_END_B)))
        else $error("trailer byte handling wrong");

endmodule
